// ----- rtl/ttfm_pkg.sv -----
// Package for the truth-table first-match gate.
// Holds sizes, payload structs, action and register codes, the control state type
// and the port resolution helpers. No dependencies.
package ttfm_pkg;

  // Table geometry and port count.
  localparam int ROWS      = 16;
  localparam int IN_COLS   = 8;
  localparam int OUT_COLS  = 8;
  localparam int NUM_PORTS = 64;

  // Derived widths.
  localparam int ENTRY_W     = 7;
  localparam int PORT_W      = 6;
  localparam int ROW_AW      = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int NROW_W      = $clog2(ROWS + 1);
  localparam int WIDTH_W     = $clog2(IN_COLS + 1);
  localparam int OW_W        = $clog2(OUT_COLS + 1);
  localparam int IN_ENT_W    = IN_COLS * ENTRY_W;
  localparam int IN_WORD_W   = IN_ENT_W + WIDTH_W;
  localparam int OUT_WORD_W  = OUT_COLS * ENTRY_W;
  localparam int MAP_W       = 48;

  // Input transaction actions.
  typedef enum logic [1:0] {
    ACT_LOAD_IN   = 2'd0,
    ACT_LOAD_OUT  = 2'd1,
    ACT_SET_WIDTH = 2'd2,
    ACT_EVAL      = 2'd3
  } action_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_ROWS_IN_USE  = 2'd0,
    CFG_OUT_WIDTH    = 2'd1,
    CFG_IN_PORT_MAP  = 2'd2,
    CFG_OUT_PORT_MAP = 2'd3
  } cfg_idx_t;

  // Control sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MERGE,
    ST_SCAN,
    ST_APPLY,
    ST_REPORT
  } state_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [3:0]  row;
    logic [2:0]  column;
    logic        entry_is_port;
    logic [5:0]  entry_value;
    logic [63:0] port_states;
  } in_item_t;

  typedef struct packed {
    logic       matched;
    logic [3:0] matched_row;
    logic [7:0] out_bits;
  } out_item_t;

  // State of port p; ports beyond the port count read as zero.
  function automatic logic port_bit(input logic [63:0] st, input logic [PORT_W-1:0] p);
    logic b;
    b = 1'b0;
    if (32'(p) < NUM_PORTS) begin
      b = st[p];
    end
    return b;
  endfunction

  // Resolve a table entry: bit 6 selects port reference, else bit 0 is literal.
  function automatic logic resolve(input logic [ENTRY_W-1:0] e, input logic [63:0] st);
    logic b;
    if (e[ENTRY_W-1]) begin
      b = port_bit(st, e[PORT_W-1:0]);
    end else begin
      b = e[0];
    end
    return b;
  endfunction

endpackage

// ----- rtl/ttfm_ram.sv -----
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module ttfm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, or read into the output register.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else begin
      rdata <= mem[addr];
    end
  end

endmodule

// ----- rtl/ttfm_row_match.sv -----
// Compares one input-table row word against the current port states.
// Depends on ttfm_pkg.
module ttfm_row_match (
  input  logic [ttfm_pkg::IN_WORD_W-1:0] row_word,
  input  logic [63:0]                    port_states,
  input  logic [ttfm_pkg::MAP_W-1:0]     in_port_map,
  output logic                           hit
);
  import ttfm_pkg::*;

  logic [WIDTH_W-1:0] width;
  logic [IN_COLS-1:0] miss;

  assign width = row_word[IN_ENT_W +: WIDTH_W];

  // Each column below the row width must resolve to its mapped input port.
  always_comb begin
    for (int c = 0; c < IN_COLS; c++) begin
      miss[c] = (c < 32'(width)) &&
                (resolve(row_word[ENTRY_W*c +: ENTRY_W], port_states) !=
                 port_bit(port_states, in_port_map[PORT_W*c +: PORT_W]));
    end
  end

  assign hit = ~|miss;

endmodule

// ----- rtl/truth_table_first_match.sv -----
// Top level of the truth-table first-match gate.
// Depends on ttfm_pkg, ttfm_ram and ttfm_row_match.
//
// Input transactions (in_valid/in_stall, payload in_data) either load the
// tables (input entry, output entry, row width) or evaluate the gate with
// the full vector of port states. Only an evaluate produces a result
// transaction on out_valid/out_stall (payload out_data).
// A load is a row read followed by a merged write-back.
// An evaluate scans the rows in order up to the first match (at most the
// saturated rows_in_use, one row word read per cycle), then on a match
// applies the saturated out_width output columns to the port states (one
// output column per cycle), then hands the result to the output register.
// The next transaction is accepted once the result is in the output
// register, even while it is stalled; a new result waits for the register.
// Configuration registers are written through cfg_we/cfg_index/cfg_wdata
// only while the block is idle; the user must keep to this, as the block
// itself does not enforce it. Synchronous active-low reset clears the
// registers, the row valid bits (every row width then reads as zero) and
// the output valid. Table entries are undefined until loaded.
module truth_table_first_match (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  ttfm_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output ttfm_pkg::out_item_t           out_data,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [ttfm_pkg::MAP_W-1:0]    cfg_wdata
);
  import ttfm_pkg::*;

  state_t                state_r, state_nxt;
  in_item_t              item_r, item_nxt;
  logic [4:0]            rows_in_use_r;
  logic [3:0]            out_width_r;
  logic [MAP_W-1:0]      in_port_map_r, out_port_map_r;
  logic [ROWS-1:0]       valid_r, valid_nxt;
  logic [ROW_AW-1:0]     scan_row_r, scan_row_nxt;
  logic [NROW_W-1:0]     nrows_r, nrows_nxt;
  logic [OW_W-1:0]       ow_r, ow_nxt;
  logic [OW_W-1:0]       col_r, col_nxt;
  logic [63:0]           st_r, st_nxt;
  logic                  found_r, found_nxt;
  logic [ROW_AW-1:0]     hit_r, hit_nxt;
  logic [OUT_WORD_W-1:0] out_word_r, out_word_nxt;
  out_item_t             out_r, out_nxt;
  logic                  out_valid_r, out_valid_nxt;

  logic                  in_fire;
  logic [ROW_AW-1:0]     ram_addr;
  logic                  in_we, out_we;
  logic [IN_WORD_W-1:0]  in_rdata, in_wdata, scan_word;
  logic [OUT_WORD_W-1:0] out_rdata, out_wdata;
  logic                  row_hit;
  logic [ROW_AW-1:0]     item_row;
  logic                  row_ok, col_in_ok, col_out_ok;
  logic [ENTRY_W-1:0]    new_entry;
  logic [7:0]            rep_bits;

  // Input-table RAM: one row word of entries plus the row width.
  ttfm_ram #(.WIDTH(IN_WORD_W), .DEPTH(ROWS)) u_in_ram (
    .clk   (clk),
    .we    (in_we),
    .addr  (ram_addr),
    .wdata (in_wdata),
    .rdata (in_rdata)
  );

  // Output-table RAM: one row word of output entries.
  ttfm_ram #(.WIDTH(OUT_WORD_W), .DEPTH(ROWS)) u_out_ram (
    .clk   (clk),
    .we    (out_we),
    .addr  (ram_addr),
    .wdata (out_wdata),
    .rdata (out_rdata)
  );

  // A row never written has width zero.
  always_comb begin
    scan_word = in_rdata;
    if (!valid_r[scan_row_r]) begin
      scan_word[IN_ENT_W +: WIDTH_W] = '0;
    end
  end

  ttfm_row_match u_match (
    .row_word    (scan_word),
    .port_states (st_r),
    .in_port_map (in_port_map_r),
    .hit         (row_hit)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Decode of the held load transaction.
  assign item_row   = ROW_AW'(item_r.row);
  assign row_ok     = (32'(item_r.row) < ROWS);
  assign col_in_ok  = (32'(item_r.column) < IN_COLS);
  assign col_out_ok = (32'(item_r.column) < OUT_COLS);
  assign new_entry  = {item_r.entry_is_port,
                       item_r.entry_is_port ? item_r.entry_value
                                            : {5'b0, item_r.entry_value[0]}};

  // Report bits: state of the port mapped to each output column.
  always_comb begin
    rep_bits = '0;
    for (int c = 0; c < OUT_COLS; c++) begin
      rep_bits[c] = port_bit(st_r, out_port_map_r[PORT_W*c +: PORT_W]);
    end
  end

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_in_use_r  <= '0;
      out_width_r    <= '0;
      in_port_map_r  <= '0;
      out_port_map_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ROWS_IN_USE:  rows_in_use_r  <= cfg_wdata[4:0];
        CFG_OUT_WIDTH:    out_width_r    <= cfg_wdata[3:0];
        CFG_IN_PORT_MAP:  in_port_map_r  <= cfg_wdata;
        CFG_OUT_PORT_MAP: out_port_map_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // State and control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    scan_row_r <= scan_row_nxt;
    nrows_r    <= nrows_nxt;
    ow_r       <= ow_nxt;
    col_r      <= col_nxt;
    st_r       <= st_nxt;
    found_r    <= found_nxt;
    hit_r      <= hit_nxt;
    out_word_r <= out_word_nxt;
    out_r      <= out_nxt;
  end

  // Sequencer: next state, RAM accesses and working register updates.
  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    valid_nxt     = valid_r;
    scan_row_nxt  = scan_row_r;
    nrows_nxt     = nrows_r;
    ow_nxt        = ow_r;
    col_nxt       = col_r;
    st_nxt        = st_r;
    found_nxt     = found_r;
    hit_nxt       = hit_r;
    out_word_nxt  = out_word_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    ram_addr      = '0;
    in_we         = 1'b0;
    out_we        = 1'b0;
    in_wdata      = in_rdata;
    out_wdata     = out_rdata;

    unique case (state_r)
      ST_IDLE: begin
        ram_addr = (action_t'(in_data.action) == ACT_EVAL) ? '0 : ROW_AW'(in_data.row);
        if (in_fire) begin
          item_nxt = in_data;
          if (action_t'(in_data.action) == ACT_EVAL) begin
            st_nxt       = in_data.port_states;
            nrows_nxt    = (32'(rows_in_use_r) > ROWS) ? NROW_W'(ROWS)
                                                      : NROW_W'(rows_in_use_r);
            ow_nxt       = (32'(out_width_r) > OUT_COLS) ? OW_W'(OUT_COLS)
                                                        : OW_W'(out_width_r);
            scan_row_nxt = '0;
            found_nxt    = 1'b0;
            hit_nxt      = '0;
            col_nxt      = '0;
            state_nxt    = (rows_in_use_r == '0) ? ST_APPLY : ST_SCAN;
          end else begin
            state_nxt = ST_MERGE;
          end
        end
      end

      // Read-modify-write of the addressed row.
      ST_MERGE: begin
        ram_addr  = item_row;
        state_nxt = ST_IDLE;
        if (!valid_r[item_row]) begin
          in_wdata[IN_ENT_W +: WIDTH_W] = '0;
        end
        case (action_t'(item_r.action))
          ACT_LOAD_IN: begin
            in_wdata[ENTRY_W*item_r.column +: ENTRY_W] = new_entry;
            in_we = row_ok && col_in_ok;
          end
          ACT_SET_WIDTH: begin
            in_wdata[IN_ENT_W +: WIDTH_W] =
              (32'(item_r.entry_value) > IN_COLS) ? WIDTH_W'(IN_COLS)
                                                 : WIDTH_W'(item_r.entry_value);
            in_we = row_ok;
          end
          ACT_LOAD_OUT: begin
            out_wdata[ENTRY_W*item_r.column +: ENTRY_W] = new_entry;
            out_we = row_ok && col_out_ok;
          end
          default: ;
        endcase
        if (in_we) begin
          valid_nxt[item_row] = 1'b1;
        end
      end

      // One row per cycle; the next row is read while this one is checked.
      ST_SCAN: begin
        ram_addr = scan_row_r + 1'b1;
        if (row_hit) begin
          found_nxt    = 1'b1;
          hit_nxt      = scan_row_r;
          out_word_nxt = out_rdata;
          state_nxt    = ST_APPLY;
        end else if (NROW_W'(scan_row_r) == nrows_r - 1'b1) begin
          state_nxt = ST_APPLY;
        end else begin
          scan_row_nxt = scan_row_r + 1'b1;
        end
      end

      // Output columns in increasing order, one per cycle.
      ST_APPLY: begin
        if (!found_r || col_r >= ow_r) begin
          state_nxt = ST_REPORT;
        end else begin
          if (32'(out_port_map_r[PORT_W*col_r +: PORT_W]) < NUM_PORTS) begin
            st_nxt[out_port_map_r[PORT_W*col_r +: PORT_W]] =
              resolve(out_word_r[ENTRY_W*col_r +: ENTRY_W], st_r);
          end
          col_nxt = col_r + 1'b1;
        end
      end

      // Hand the result to the output register once it is free.
      ST_REPORT: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt.matched     = found_r;
          out_nxt.matched_row = 4'(hit_r);
          out_nxt.out_bits    = rep_bits;
          out_valid_nxt       = 1'b1;
          state_nxt           = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule
